// ===== rtl/mbss_pkg.sv =====
// mbss_pkg: shared types and defaults for the batch median core
// holds the controller/datapath command and status structs
// no dependencies
package mbss_pkg;

   localparam int DefaultDepth       = 64;
   localparam int DefaultSampleWidth = 32;

   // one-hot style commands from the controller to the datapath
   typedef struct packed {
      logic load;    // store the accepted request sample
      logic rd_pos;  // read the entry at the current sort position
      logic first;   // take the position entry as the running minimum
      logic scan;    // compare one entry against the running minimum
      logic swap1;   // write the old position value to the minimum's slot
      logic swap2;   // write the minimum to the position, advance position
      logic finish;  // form the median, load the result, clear the batch
   } cmd_type;

   typedef struct packed {
      logic pos_last;  // sort position is the last stored entry
      logic cmp_last;  // entry being compared is the last stored entry
      logic pos_half;  // sort position is the upper middle index
      logic out_free;  // result register can take a new result
   } status_type;

endpackage

// ===== rtl/median_by_selection_sort_core.sv =====
// median_by_selection_sort_core: top level of the batch median core
// joins the controller and the datapath
// depends on mbss_pkg, mbss_ctrl, mbss_datapath

// Batch median of signed fixed-point samples. Each request carries one
// sample; the request with last_sample set closes the batch. Samples are
// written into a store of DEPTH entries with one write port and one
// registered read port, one per cycle while the block is loading; samples
// past DEPTH are dropped and flagged in overflow. After the closing request
// the block runs selection sort on the store, one compare per cycle through
// the store's registered read port, but only over positions 0 to n/2, which
// is all the median needs. Each pass at position p reads and compares the
// entries from p to n - 1, then makes two swap writes through the single
// write port when p is below n/2. Once the result register is free, the
// result is formed from the sort. The result is twice the median (sum of the
// two middle values, or twice the middle one), exact, with the number of
// samples used and the overflow flag. No request is taken during the sort;
// loading of the next batch may start while the previous result is still
// waiting on rsp_ready.
module median_by_selection_sort_core
   import mbss_pkg::*;
#(
   parameter int DEPTH        = DefaultDepth,
   parameter int SAMPLE_WIDTH = DefaultSampleWidth,
   localparam int CW = $clog2(DEPTH + 1)
)
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                    req_last_sample,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SAMPLE_WIDTH:0]   rsp_median_doubled,
   output logic [CW-1:0]           rsp_sample_count,
   output logic                    rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   // sequencing: load, sort passes, swaps, result handoff
   mbss_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_ready       (req_ready),
      .status          (status),
      .cmd             (cmd)
   );

   // store, running minimum, median adder and result register
   mbss_datapath #(
      .DEPTH        (DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sample         (req_sample),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

// ===== rtl/mbss_ctrl.sv =====
// mbss_ctrl: sequencing state machine of the batch median core
// drives datapath commands, reads datapath status
// depends on mbss_pkg
module mbss_ctrl
   import mbss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_sample,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_LOAD    = 3'd0;
   localparam logic [2:0] S_RDPOS   = 3'd1;
   localparam logic [2:0] S_FIRST   = 3'd2;
   localparam logic [2:0] S_SCAN    = 3'd3;
   localparam logic [2:0] S_PASSEND = 3'd4;
   localparam logic [2:0] S_SWAP1   = 3'd5;
   localparam logic [2:0] S_SWAP2   = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_sample) begin
                  state_in = S_RDPOS;
               end
            end
         end
         S_RDPOS: begin
            cmd.rd_pos = 1'b1;
            state_in   = S_FIRST;
         end
         S_FIRST: begin
            cmd.first = 1'b1;
            state_in  = status.pos_last ? S_PASSEND : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.cmp_last) begin
               state_in = S_PASSEND;
            end
         end
         S_PASSEND: begin
            state_in = status.pos_half ? S_DONE : S_SWAP1;
         end
         S_SWAP1: begin
            cmd.swap1 = 1'b1;
            state_in  = S_SWAP2;
         end
         S_SWAP2: begin
            cmd.swap2 = 1'b1;
            state_in  = S_RDPOS;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/mbss_datapath.sv =====
// mbss_datapath: sample store, selection-sort registers and result register
// executes mbss_ctrl commands, reports status back
// depends on mbss_pkg
module mbss_datapath
   import mbss_pkg::*;
#(
   parameter int DEPTH        = DefaultDepth,
   parameter int SAMPLE_WIDTH = DefaultSampleWidth,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [SAMPLE_WIDTH:0]   rsp_median_doubled,
   output logic [CW-1:0]           rsp_sample_count,
   output logic                    rsp_overflow
);

   logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [SAMPLE_WIDTH-1:0] wr_data;
   logic [AW-1:0]           rd_addr;

   logic [CW-1:0] fill_ff, fill_in;
   logic          dropped_ff, dropped_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic signed [SAMPLE_WIDTH-1:0] best_val_ff, best_val_in;
   logic signed [SAMPLE_WIDTH-1:0] pos_val_ff, pos_val_in;
   logic signed [SAMPLE_WIDTH-1:0] lo_val_ff, lo_val_in;
   logic signed [SAMPLE_WIDTH:0]   median_ff, median_in;
   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] last_idx;
   logic signed [SAMPLE_WIDTH:0] best_ext;
   logic signed [SAMPLE_WIDTH:0] other_ext;

   assign last_idx  = fill_ff - CW'(1);
   assign best_ext  = {best_val_ff[SAMPLE_WIDTH-1], best_val_ff};
   // odd count doubles the middle, even count adds the lower middle
   assign other_ext = fill_ff[0] ? best_ext : {lo_val_ff[SAMPLE_WIDTH-1], lo_val_ff};

   assign status.pos_last = (CW'(pos_ff) == last_idx);
   assign status.cmp_last = (CW'(cmp_idx_ff) == last_idx);
   assign status.pos_half = (CW'(pos_ff) == (fill_ff >> 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = best_val_ff;
      rd_addr      = pos_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      pos_in       = pos_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      pos_val_in   = pos_val_ff;
      lo_val_in    = lo_val_ff;
      median_in    = median_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         if (fill_ff < CW'(DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = fill_ff[AW-1:0];
            wr_data = req_sample;
            fill_in = fill_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end

      // fetch the entry at the current sort position
      if (cmd.rd_pos) begin
         rd_addr = pos_ff;
      end

      if (cmd.first) begin
         best_val_in = $signed(rd_data_ff);
         pos_val_in  = $signed(rd_data_ff);
         best_idx_in = pos_ff;
         cmp_idx_in  = pos_ff + AW'(1);
         rd_addr     = pos_ff + AW'(1);
      end

      if (cmd.scan) begin
         // strict compare keeps the first minimum found
         if ($signed(rd_data_ff) < best_val_ff) begin
            best_val_in = $signed(rd_data_ff);
            best_idx_in = cmp_idx_ff;
         end
         cmp_idx_in = cmp_idx_ff + AW'(1);
         rd_addr    = cmp_idx_ff + AW'(1);
      end

      if (cmd.swap1) begin
         wr_en     = 1'b1;
         wr_addr   = best_idx_ff;
         wr_data   = pos_val_ff;
         lo_val_in = best_val_ff;
      end

      if (cmd.swap2) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
         wr_data = best_val_ff;
         pos_in  = pos_ff + AW'(1);
      end

      if (cmd.finish) begin
         median_in    = best_ext + other_ext;
         count_in     = fill_ff;
         overflow_in  = dropped_ff;
         rsp_valid_in = 1'b1;
         fill_in      = '0;
         dropped_in   = 1'b0;
         pos_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      pos_val_ff  <= pos_val_in;
      lo_val_ff   <= lo_val_in;
      median_ff   <= median_in;
      count_ff    <= count_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;
   assign rsp_sample_count   = count_ff;
   assign rsp_overflow       = overflow_ff;

endmodule

// ===== bench/median_by_selection_sort_core_tb.sv =====
// median_by_selection_sort_core_tb: self-checking bench for the batch median core
// directed batch table, then random batches, scored against hand-typed results or a local median predictor
// depends on mbss_pkg and median_by_selection_sort_core
module median_by_selection_sort_core_tb;
   import mbss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DefaultDepth;
   localparam int SW    = DefaultSampleWidth;
   localparam int CW    = $clog2(DEPTH + 1);

   // random part sizing, the last stretch runs with no idling on either side
   localparam int RANDOM_ITEMS   = 1460;
   localparam int CALM_ITEMS     = 150;
   // long receiver hold-off so the core fills up and stops taking requests
   localparam int PRESSURE_START = 1200;
   localparam int PRESSURE_LEN   = 800;
   localparam int DRAIN_CYCLES   = 64;

   // one result as the core reports it
   typedef struct packed {
      logic [SW:0]   doubled;
      logic [CW-1:0] count;
      logic          dropped;
   } median_t;

   // one directed table row, sent reps times, last flag only on the final copy
   typedef struct {
      logic [SW-1:0] sample;
      bit            last;
      int            reps;
      bit            typed;
      logic [SW:0]   doubled;
      logic [CW-1:0] count;
      bit            dropped;
   } stim_row_t;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_EDGES,
      SPREAD_MIXED
   } spread_t;

   localparam int NUM_ROWS = 20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [SW-1:0]     req_sample = '0;
   logic              req_last_sample = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [SW:0]       rsp_median_doubled;
   logic [CW-1:0]     rsp_sample_count;
   logic              rsp_overflow;

   // predictor copy of the batch state
   logic signed [SW-1:0] batch_store [DEPTH];
   int                   batch_fill = 0;
   bit                   batch_dropped = 1'b0;

   median_t median_q [$];

   int  mismatch_count = 0;
   int  requests_sent = 0;
   int  medians_seen = 0;
   int  overflow_seen = 0;
   int  full_seen = 0;
   bit  calm = 1'b0;
   bit  sender_jitter = 1'b1;

   stim_row_t directed_rows [NUM_ROWS] = '{
      // single samples at the extremes, median is the sample doubled
      '{32'h7FFF_FFFF, 1'b1, 1, 1'b1, 33'h0_FFFF_FFFE, 7'd1, 1'b0},
      '{32'h8000_0000, 1'b1, 1, 1'b1, 33'h1_0000_0000, 7'd1, 1'b0},
      '{32'h0000_0000, 1'b1, 1, 1'b1, 33'h0_0000_0000, 7'd1, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1, 1'b1, 33'h1_FFFF_FFFE, 7'd1, 1'b0},
      // min plus max, sum is minus one lsb
      '{32'h8000_0000, 1'b0, 1, 1'b0, '0, '0, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1, 1'b1, 33'h1_FFFF_FFFF, 7'd2, 1'b0},
      // odd count, unsorted
      '{32'h0000_0005, 1'b0, 1, 1'b0, '0, '0, 1'b0},
      '{32'hFFFF_FFFD, 1'b0, 1, 1'b0, '0, '0, 1'b0},
      '{32'h0000_0064, 1'b1, 1, 1'b0, '0, '0, 1'b0},
      // all equal, both middles at full scale
      '{32'h7FFF_FFFF, 1'b1, 4, 1'b1, 33'h0_FFFF_FFFE, 7'd4, 1'b0},
      // even count, half step kept in the doubled form
      '{32'h0000_0001, 1'b0, 1, 1'b0, '0, '0, 1'b0},
      '{32'h0000_0002, 1'b1, 1, 1'b1, 33'h0_0000_0003, 7'd2, 1'b0},
      // mixed signs, five values
      '{32'h0000_0009, 1'b0, 1, 1'b0, '0, '0, 1'b0},
      '{32'hFFFF_FFF7, 1'b0, 1, 1'b0, '0, '0, 1'b0},
      '{32'h0000_0000, 1'b0, 1, 1'b0, '0, '0, 1'b0},
      '{32'h0000_0003, 1'b0, 1, 1'b0, '0, '0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1, 1'b0, '0, '0, 1'b0},
      // store full, closing sample is dropped
      '{32'h0001_0000, 1'b0, 64, 1'b0, '0, '0, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1, 1'b1, 33'h0_0002_0000, 7'd64, 1'b1},
      // next batch starts clean, dropped flag cleared
      '{32'h0000_0004, 1'b1, 1, 1'b1, 33'h0_0000_0008, 7'd1, 1'b0}
   };

   median_by_selection_sort_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_last_sample    (req_last_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_overflow       (rsp_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor: store the sample (or mark it dropped), and on the closing
   // sample sort the batch and form twice the median
   function automatic bit absorb_sample(input logic [SW-1:0] s, input bit last,
                                        output median_t res);
      longint work [DEPTH];
      longint held;
      longint twice;
      int     n;
      int     i;
      int     j;
      res = '0;
      if (batch_fill < DEPTH) begin
         batch_store[batch_fill] = s;
         batch_fill++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (!last) return 1'b0;
      n = batch_fill;
      for (i = 0; i < n; i++) work[i] = longint'(batch_store[i]);
      // insertion sort, ascending; any stable order gives the same median
      for (i = 1; i < n; i++) begin
         held = work[i];
         j = i - 1;
         while (j >= 0 && work[j] > held) begin
            work[j + 1] = work[j];
            j--;
         end
         work[j + 1] = held;
      end
      if (n % 2 == 0) twice = work[n / 2] + work[n / 2 - 1];
      else twice = 2 * work[n / 2];
      res.doubled = twice[SW:0];
      res.count   = n[CW-1:0];
      res.dropped = batch_dropped;
      batch_fill    = 0;
      batch_dropped = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [SW-1:0] random_sample(input spread_t spread);
      spread_t pick;
      logic [SW-1:0] edges [7];
      edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h7FFF_FFFE, 32'h8000_0001};
      pick = spread;
      if (pick == SPREAD_MIXED) pick = spread_t'($urandom_range(0, 2));
      case (pick)
         SPREAD_NARROW: begin
            // small window so duplicates are common
            return SW'($urandom_range(0, 16)) - SW'(8);
         end
         SPREAD_EDGES: begin
            return edges[$urandom_range(0, 6)];
         end
         default: begin
            return SW'($urandom);
         end
      endcase
   endfunction

   // offer one request, hold it until taken, then feed the predictor
   task automatic send_request(input logic [SW-1:0] s, input bit last, input bit typed,
                               input median_t typed_res);
      median_t predicted;
      int      gap;
      if (!calm && sender_jitter && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_last_sample <= last;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      if (absorb_sample(s, last, predicted)) begin
         // hand-typed rows override the predictor, the predictor state still advances
         median_q.push_back(typed ? typed_res : predicted);
      end
   endtask

   // result checker: every accepted result against the oldest pending median
   always @(posedge clock) begin : rsp_check
      median_t got;
      median_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_median_doubled, rsp_sample_count, rsp_overflow};
         medians_seen++;
         if (got.dropped === 1'b1) overflow_seen++;
         if (got.count == CW'(DEPTH)) full_seen++;
         if (median_q.size() == 0) begin
            $error("unexpected result: median_doubled %0d count %0d overflow %0b",
                   $signed(got.doubled), got.count, got.dropped);
            mismatch_count++;
         end else begin
            want = median_q.pop_front();
            if (got.doubled !== want.doubled) begin
               $error("median_doubled: expected %0d, actual %0d",
                      $signed(want.doubled), $signed(got.doubled));
               mismatch_count++;
            end
            if (got.count !== want.count) begin
               $error("sample_count: expected %0d, actual %0d", want.count, got.count);
               mismatch_count++;
            end
            if (got.dropped !== want.dropped) begin
               $error("overflow: expected %0b, actual %0b", want.dropped, got.dropped);
               mismatch_count++;
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off, none in the calm tail
   initial begin : rsp_side
      int  cycle_count;
      int  hold;
      bit  pressure_done;
      bit  jitter;
      cycle_count   = 0;
      hold          = 0;
      pressure_done = 1'b0;
      jitter        = 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         cycle_count++;
         // switch between stalling and clean stretches now and then
         if (cycle_count % 256 == 0) jitter = ($urandom_range(0, 2) != 0);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (!pressure_done && !calm && cycle_count >= PRESSURE_START) begin
            // sender keeps offering, the core must fill and back off req_ready
            pressure_done = 1'b1;
            hold = PRESSURE_LEN - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && jitter && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 7) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // sender: reset, directed table, random batches, drain, verdict
   initial begin : req_side
      int      row;
      int      rep;
      int      k;
      int      len;
      int      random_sent;
      int      pick;
      spread_t spread;
      stim_row_t r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      for (row = 0; row < NUM_ROWS; row++) begin
         r = directed_rows[row];
         for (rep = 0; rep < r.reps; rep++) begin
            send_request(r.sample, r.last && (rep == r.reps - 1), r.typed,
                         {r.doubled, r.count, r.dropped});
         end
      end

      // random batches: mostly short, some mid size, a few around the store depth
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) len = $urandom_range(1, 12);
         else if (pick < 95) len = $urandom_range(13, 48);
         else len = $urandom_range(62, 70);
         spread = spread_t'($urandom_range(0, 3));
         sender_jitter = ($urandom_range(0, 3) != 0);
         for (k = 0; k < len; k++) begin
            calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
            send_request(random_sample(spread), k == len - 1, 1'b0, '0);
            random_sent++;
         end
      end
      req_valid       <= 1'b0;
      req_last_sample <= 1'b0;

      // drain pending medians, then watch a little longer for strays
      while (median_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests sent, %0d medians checked", requests_sent, medians_seen);
      $display("summary: %0d batches with dropped samples, %0d with a full store",
               overflow_seen, full_seen);
      if (mismatch_count == 0) begin
         $display("median_by_selection_sort_core_tb: clean");
      end else begin
         $display("median_by_selection_sort_core_tb: errors");
      end
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("median_by_selection_sort_core_tb: errors");
      $finish;
   end

endmodule
